// ===== rtl/ppf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types, constants and arithmetic helpers of the pointer position filter.
// ----------------------------------------------------------------------------
package ppf_pkg;

  // screen geometry
  localparam int unsigned POS_W        = 11;
  localparam int unsigned RAW_W        = 16;
  localparam int unsigned SCREEN_MAX_X = 1919;
  localparam int unsigned SCREEN_MAX_Y = 1079;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // divider operand widths: (raw - low) * max over a 16-bit span
  localparam int unsigned DIVIDEND_W = RAW_W + POS_W;
  localparam int unsigned DIV_CNT_W  = $clog2(POS_W);

  // history
  localparam int unsigned HIST_DEPTH = 3;
  localparam int unsigned HIST_CNT_W = 2;

  // spring limiter: 70/100 is applied as 7/10, the divide by ten as
  // a multiply by 205 and shift by 11, exact below 1029
  localparam int unsigned SPRING_PASS     = 24;
  localparam int unsigned SPRING_STEP_MAX = 96;
  localparam int unsigned SPRING_NUM      = 70;
  localparam int unsigned SPRING_DEN      = 100;
  localparam int unsigned SPRING_NUM_RED  = 7;
  localparam int unsigned RECIP_TEN       = 205;
  localparam int unsigned RECIP_SHIFT     = 11;
  // smallest magnitude whose scaled step exceeds the clamp
  localparam int unsigned SPRING_SAT_MAG  =
      ((SPRING_STEP_MAX + 1) * SPRING_DEN + SPRING_NUM - 1) / SPRING_NUM;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE   = 3'd0,
    REG_CENTER_X      = 3'd1,
    REG_CENTER_Y      = 3'd2,
    REG_WINDOW_LEFT   = 3'd3,
    REG_WINDOW_RIGHT  = 3'd4,
    REG_WINDOW_TOP    = 3'd5,
    REG_WINDOW_BOTTOM = 3'd6
  } reg_idx_e;

  // filter modes
  typedef enum logic [1:0] {
    MODE_DIRECT   = 2'd0,
    MODE_MEAN2    = 2'd1,
    MODE_WEIGHTED = 2'd2,
    MODE_DIRECT_B = 2'd3
  } filter_mode_e;

  typedef struct packed {
    filter_mode_e           filter_mode;
    logic [RAW_W-1:0]       center_x;
    logic [RAW_W-1:0]       center_y;
    logic [RAW_W-1:0]       window_left;
    logic [RAW_W-1:0]       window_right;
    logic [RAW_W-1:0]       window_top;
    logic [RAW_W-1:0]       window_bottom;
  } cfg_t;

  // divider request and response
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [RAW_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [POS_W-1:0] quotient;
  } div_rsp_t;

  // spring limiter for one axis
  function automatic logic [POS_W-1:0] spring_axis(
    input logic [POS_W-1:0] tgt,
    input logic [POS_W-1:0] newest,
    input logic [POS_W-1:0] maxv
  );
    logic signed [POS_W+1:0] delta;
    logic signed [POS_W+1:0] neg_delta;
    logic [POS_W:0]          mag;
    logic [7:0]              mag_lo;
    logic [9:0]              p7;
    logic [17:0]             p205;
    logic [6:0]              step;
    logic signed [POS_W+2:0] sum;
    logic [POS_W-1:0]        res;
    delta     = $signed({2'b00, tgt}) - $signed({2'b00, newest});
    neg_delta = -delta;
    mag       = delta[POS_W+1] ? neg_delta[POS_W:0] : delta[POS_W:0];
    mag_lo    = mag[7:0];
    p7        = {2'b00, mag_lo} * 10'(SPRING_NUM_RED);
    p205      = {8'b0, p7} * 18'(RECIP_TEN);
    if (mag >= (POS_W+1)'(SPRING_SAT_MAG)) begin
      step = 7'(SPRING_STEP_MAX);
    end else begin
      step = p205[RECIP_SHIFT +: 7];
    end
    if (delta[POS_W+1]) begin
      sum = $signed({3'b000, newest}) - $signed({7'b0, step});
    end else begin
      sum = $signed({3'b000, newest}) + $signed({7'b0, step});
    end
    if (mag <= (POS_W+1)'(SPRING_PASS)) begin
      res = tgt;
    end else if (sum < 0) begin
      res = '0;
    end else if (sum > $signed({3'b000, maxv})) begin
      res = maxv;
    end else begin
      res = sum[POS_W-1:0];
    end
    return res;
  endfunction

  // output averaging for one axis; cnt is the history fill before the push
  function automatic logic [POS_W-1:0] avg_axis(
    input logic [POS_W-1:0]      cur,
    input logic [POS_W-1:0]      prev1,
    input logic [POS_W-1:0]      prev2,
    input filter_mode_e          mode,
    input logic [HIST_CNT_W-1:0] cnt
  );
    logic [POS_W:0]   sum2;
    logic [POS_W+1:0] sum4;
    logic [POS_W-1:0] res;
    sum2 = {1'b0, cur} + {1'b0, prev1};
    sum4 = {1'b0, cur, 1'b0} + {2'b00, prev1} + {2'b00, prev2};
    res  = cur;
    if ((mode == MODE_MEAN2 || mode == MODE_WEIGHTED) && cnt != '0) begin
      if (mode == MODE_WEIGHTED && cnt >= HIST_CNT_W'(2)) begin
        res = sum4[POS_W+1:2];
      end else begin
        res = sum2[POS_W:1];
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/ppf_if.sv =====
// ----------------------------------------------------------------------------
// ppf_if
// Valid/ready channels of the pointer position filter: raw samples in,
// filtered positions out, and the register write channel.
// ----------------------------------------------------------------------------

// raw camera sample channel
interface ppf_in_if import ppf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_x;
  logic [RAW_W-1:0] raw_y;
  logic             sample_valid;

  modport source (output valid, output raw_x, output raw_y, output sample_valid,
                  input ready);
  modport sink   (input valid, input raw_x, input raw_y, input sample_valid,
                  output ready);
endinterface

// filtered position channel
interface ppf_out_if import ppf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             pos_valid;

  modport source (output valid, output pos_x, output pos_y, output pos_valid,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_valid,
                  output ready);
endinterface

// register write channel
interface ppf_cfg_if import ppf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ppf_regs.sv =====
// ----------------------------------------------------------------------------
// ppf_regs
// Configuration register file: decodes write beats by register index.
// ----------------------------------------------------------------------------
module ppf_regs import ppf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppf_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t regs_q, regs_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // index decode
  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_FILTER_MODE:   regs_d.filter_mode   = filter_mode_e'(cfg_i.data[1:0]);
        REG_CENTER_X:      regs_d.center_x      = cfg_i.data;
        REG_CENTER_Y:      regs_d.center_y      = cfg_i.data;
        REG_WINDOW_LEFT:   regs_d.window_left   = cfg_i.data;
        REG_WINDOW_RIGHT:  regs_d.window_right  = cfg_i.data;
        REG_WINDOW_TOP:    regs_d.window_top    = cfg_i.data;
        REG_WINDOW_BOTTOM: regs_d.window_bottom = cfg_i.data;
        default:           regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o = regs_q;

endmodule

// ===== rtl/ppf_div.sv =====
// ----------------------------------------------------------------------------
// ppf_div
// Shared restoring divider, one quotient bit per cycle. The caller guarantees
// the quotient fits in POS_W bits (dividend below divisor * 2**POS_W).
// ----------------------------------------------------------------------------
module ppf_div import ppf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [RAW_W-1:0]     rem_q;
  logic [POS_W-1:0]     num_q;
  logic [POS_W-1:0]     quo_q;
  logic [RAW_W-1:0]     dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [RAW_W:0]       trial;
  logic                 fits;
  logic [RAW_W:0]       diff;

  // one trial subtraction per cycle
  assign trial = {rem_q, num_q[POS_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(POS_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[DIVIDEND_W-1:POS_W];
      num_q <= req_i.dividend[POS_W-1:0];
      dsr_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
      num_q <= {num_q[POS_W-2:0], 1'b0};
      quo_q <= {quo_q[POS_W-2:0], fits};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/pointer_position_filter.sv =====
// ----------------------------------------------------------------------------
// pointer_position_filter
// Maps raw camera coordinates to a screen position, limits jumps and averages.
// ----------------------------------------------------------------------------
// One sample is taken at a time; in_i.ready is high only while the sequencer
// is idle. With a usable calibration window each axis goes through the one
// shared multiply and 11-step restoring divider in turn. An axis skips the
// divider in center-shift mode or when raw is at or beyond a window edge,
// which shortens the sample. An invalid sample goes from idle straight to
// the average step and repeats the last position. The result sits in an
// output register, so the next sample is accepted while it waits for
// out_o.ready; the sample after it holds in its last step until that is
// taken.
// ----------------------------------------------------------------------------
module pointer_position_filter import ppf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppf_in_if.sink     in_i,
  ppf_out_if.source  out_o,
  ppf_cfg_if.sink    cfg_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MAP_X  = 7'b0000010,
    S_DIV_X  = 7'b0000100,
    S_MAP_Y  = 7'b0001000,
    S_DIV_Y  = 7'b0010000,
    S_SPRING = 7'b0100000,
    S_AVG    = 7'b1000000
  } state_e;

  localparam logic [POS_W-1:0] MAX_X = POS_W'(SCREEN_MAX_X);
  localparam logic [POS_W-1:0] MAX_Y = POS_W'(SCREEN_MAX_Y);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e state_q, state_d;

  logic [RAW_W-1:0]      raw_x_q, raw_y_q;
  logic                  smp_valid_q;
  logic [POS_W-1:0]      map_x_q, map_x_d, map_y_q, map_y_d;
  logic [POS_W-1:0]      hist_x_q [HIST_DEPTH];
  logic [POS_W-1:0]      hist_y_q [HIST_DEPTH];
  logic [HIST_CNT_W-1:0] hist_cnt_q;
  logic [POS_W-1:0]      held_x_q, held_y_q;
  logic [POS_W-1:0]      pos_x_q, pos_y_q;
  logic                  pos_valid_q;
  logic                  out_valid_q;

  logic                  in_beat, out_free, load_out;
  logic                  win_ok, is_y;
  logic [RAW_W-1:0]      sel_raw, sel_low, sel_high, sel_center;
  logic [POS_W-1:0]      sel_max, map_val, avg_x, avg_y;
  logic [RAW_W-1:0]      diff, span;
  logic signed [RAW_W+1:0] shifted;

  ppf_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ppf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign load_out   = (state_q == S_AVG) && out_free;

  // axis operand select for the shared map step
  assign win_ok     = (cfg.window_right > cfg.window_left) &&
                      (cfg.window_bottom > cfg.window_top);
  assign is_y       = (state_q == S_MAP_Y);
  assign sel_raw    = is_y ? raw_y_q : raw_x_q;
  assign sel_low    = is_y ? cfg.window_top : cfg.window_left;
  assign sel_high   = is_y ? cfg.window_bottom : cfg.window_right;
  assign sel_center = is_y ? cfg.center_y : cfg.center_x;
  assign sel_max    = is_y ? MAX_Y : MAX_X;
  assign diff       = sel_raw - sel_low;
  assign span       = sel_high - sel_low;
  assign shifted    = $signed({2'b00, sel_raw}) +
                      $signed({(RAW_W + 2 - POS_W)'(0), sel_max >> 1}) -
                      $signed({2'b00, sel_center});

  // window scaling goes through the divider unless the axis saturates
  assign div_req.start    = (state_q == S_MAP_X || state_q == S_MAP_Y) && win_ok &&
                            (sel_raw > sel_low) && (sel_raw < sel_high);
  assign div_req.dividend = {(DIVIDEND_W - RAW_W)'(0), diff} *
                            {(DIVIDEND_W - POS_W)'(0), sel_max};
  assign div_req.divisor  = span;

  // map result when the divider is not needed
  always_comb begin
    if (win_ok) begin
      map_val = (sel_raw <= sel_low) ? '0 : sel_max;
    end else if (shifted < 0) begin
      map_val = '0;
    end else if (shifted > $signed({(RAW_W + 2 - POS_W)'(0), sel_max})) begin
      map_val = sel_max;
    end else begin
      map_val = shifted[POS_W-1:0];
    end
  end

  // output averaging against the history before the push
  assign avg_x = avg_axis(map_x_q, hist_x_q[0], hist_x_q[1], cfg.filter_mode, hist_cnt_q);
  assign avg_y = avg_axis(map_y_q, hist_y_q[0], hist_y_q[1], cfg.filter_mode, hist_cnt_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    map_x_d = map_x_q;
    map_y_d = map_y_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d = in_i.sample_valid ? S_MAP_X : S_AVG;
        end
      end
      S_MAP_X: begin
        if (div_req.start) begin
          state_d = S_DIV_X;
        end else begin
          map_x_d = map_val;
          state_d = S_MAP_Y;
        end
      end
      S_DIV_X: begin
        if (div_rsp.done) begin
          map_x_d = div_rsp.quotient;
          state_d = S_MAP_Y;
        end
      end
      S_MAP_Y: begin
        if (div_req.start) begin
          state_d = S_DIV_Y;
        end else begin
          map_y_d = map_val;
          state_d = S_SPRING;
        end
      end
      S_DIV_Y: begin
        if (div_rsp.done) begin
          map_y_d = div_rsp.quotient;
          state_d = S_SPRING;
        end
      end
      S_SPRING: begin
        if (hist_cnt_q != '0) begin
          map_x_d = spring_axis(map_x_q, hist_x_q[0], MAX_X);
          map_y_d = spring_axis(map_y_q, hist_y_q[0], MAX_Y);
        end
        state_d = S_AVG;
      end
      S_AVG: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hist_cnt_q  <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_x_q[i] <= '0;
        hist_y_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // history push and held position on a valid sample
      if (load_out && smp_valid_q) begin
        hist_x_q[0] <= map_x_q;
        hist_y_q[0] <= map_y_q;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          hist_x_q[i] <= hist_x_q[i-1];
          hist_y_q[i] <= hist_y_q[i-1];
        end
        if (hist_cnt_q != HIST_CNT_W'(HIST_DEPTH)) begin
          hist_cnt_q <= hist_cnt_q + 1'b1;
        end
        held_x_q <= avg_x;
        held_y_q <= avg_y;
      end
    end
  end

  // sample and result payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      raw_x_q     <= in_i.raw_x;
      raw_y_q     <= in_i.raw_y;
      smp_valid_q <= in_i.sample_valid;
    end
    map_x_q <= map_x_d;
    map_y_q <= map_y_d;
    if (load_out) begin
      pos_x_q     <= smp_valid_q ? avg_x : held_x_q;
      pos_y_q     <= smp_valid_q ? avg_y : held_y_q;
      pos_valid_q <= smp_valid_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pos_x     = pos_x_q;
  assign out_o.pos_y     = pos_y_q;
  assign out_o.pos_valid = pos_valid_q;

`ifndef NO_ASSERTIONS
  // the divider only runs while the sequencer waits on it
  a_div_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == S_DIV_X || state_q == S_DIV_Y))
    else $error("divider busy outside a divide state");

  // a divide result never arrives unexpected
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_X || state_q == S_DIV_Y))
    else $error("divider done outside a divide state");

  // an accepted sample always starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> state_q != S_IDLE)
    else $error("sample beat did not leave idle");

  // limited positions stay on screen
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AVG && smp_valid_q) |-> (map_x_q <= MAX_X && map_y_q <= MAX_Y))
    else $error("mapped position off screen");
`endif

endmodule

// ===== sim/tb_pointer_position_filter.sv =====
// ----------------------------------------------------------------------------
// tb_pointer_position_filter
// Self-checking bench for the pointer position filter. A directed table walks
// the reset state, the extremes of the raw fields, every filter mode and the
// short-history cases, then random phases under fixed and random calibrations follow.
// Every result beat is checked against an expected position, typed or from the predictor.
// ----------------------------------------------------------------------------
module tb_pointer_position_filter;
  import ppf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_X         = int'(SCREEN_MAX_X);
  localparam int MAX_Y         = int'(SCREEN_MAX_Y);
  localparam int JUMP_PASS     = 24;
  localparam int JUMP_STEP_MAX = 96;
  localparam int JUMP_NUM      = 70;
  localparam int JUMP_DEN      = 100;
  localparam int SETTLE_CYC    = 4;
  localparam int TAIL_CYC      = 40;
  localparam int HOLD_CYC      = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 75;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             v;
  } pos_t;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [15:0]      a;
    logic [15:0]      b;
    logic             v;
    logic             typed;
    logic [POS_W-1:0] ex;
    logic [POS_W-1:0] ey;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ppf_in_if  in_if();
  ppf_out_if out_if();
  ppf_cfg_if cfg_if();

  pointer_position_filter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // expected positions, oldest first
  pos_t pos_q[$];
  int   err_cnt = 0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;

  // predictor copy of registers and history
  filter_mode_e     pred_mode;
  logic [15:0]      cen_x, cen_y, win_l, win_r, win_t, win_b;
  logic [POS_W-1:0] hist_x[3];
  logic [POS_W-1:0] hist_y[3];
  int               hist_wr;
  int               hist_fill;
  logic [POS_W-1:0] last_x, last_y;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int clamp_pos(input int v, input int maxv);
    if (v < 0) return 0;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int scale_pos(input int raw, input int lo, input int hi, input int maxv);
    if (raw <= lo) return 0;
    if (raw >= hi) return maxv;
    return ((raw - lo) * maxv) / (hi - lo);
  endfunction

  function automatic int shift_pos(input int raw, input int cen, input int maxv);
    return clamp_pos(raw + maxv / 2 - cen, maxv);
  endfunction

  // spring: small moves pass, large ones move 70 percent, at most 96
  function automatic int limit_jump(input int tgt, input int newest, input int maxv);
    int delta;
    int step;
    delta = tgt - newest;
    if (delta <= JUMP_PASS && delta >= -JUMP_PASS) return tgt;
    step = (delta * JUMP_NUM) / JUMP_DEN;
    if (step > JUMP_STEP_MAX) step = JUMP_STEP_MAX;
    else if (step < -JUMP_STEP_MAX) step = -JUMP_STEP_MAX;
    return clamp_pos(newest + step, maxv);
  endfunction

  task automatic apply_reg(input reg_idx_e idx, input logic [15:0] d);
    case (idx)
      REG_FILTER_MODE:   pred_mode = filter_mode_e'(d[1:0]);
      REG_CENTER_X:      cen_x = d;
      REG_CENTER_Y:      cen_y = d;
      REG_WINDOW_LEFT:   win_l = d;
      REG_WINDOW_RIGHT:  win_r = d;
      REG_WINDOW_TOP:    win_t = d;
      REG_WINDOW_BOTTOM: win_b = d;
      default: ;
    endcase
  endtask

  task automatic filter_sample(input logic [15:0] rx, input logic [15:0] ry, input logic sv,
                               output pos_t res);
    int mx, my, ox, oy, s1, s2;
    if (!sv) begin
      res = '{last_x, last_y, 1'b0};
    end else begin
      // map raw to screen
      if (win_r > win_l && win_b > win_t) begin
        mx = scale_pos(int'(rx), int'(win_l), int'(win_r), MAX_X);
        my = scale_pos(int'(ry), int'(win_t), int'(win_b), MAX_Y);
      end else begin
        mx = shift_pos(int'(rx), int'(cen_x), MAX_X);
        my = shift_pos(int'(ry), int'(cen_y), MAX_Y);
      end
      // spring against the newest entry
      if (hist_fill != 0) begin
        mx = limit_jump(mx, int'(hist_x[(hist_wr + 2) % 3]), MAX_X);
        my = limit_jump(my, int'(hist_y[(hist_wr + 2) % 3]), MAX_Y);
      end
      // push history
      hist_x[hist_wr] = POS_W'(mx);
      hist_y[hist_wr] = POS_W'(my);
      hist_wr = (hist_wr + 1) % 3;
      if (hist_fill < 3) hist_fill++;
      // averaging
      ox = mx;
      oy = my;
      s1 = (hist_wr + 1) % 3;
      s2 = hist_wr;
      if (pred_mode == MODE_MEAN2 || pred_mode == MODE_WEIGHTED) begin
        if (pred_mode == MODE_WEIGHTED && hist_fill >= 3) begin
          ox = (2 * mx + int'(hist_x[s1]) + int'(hist_x[s2])) / 4;
          oy = (2 * my + int'(hist_y[s1]) + int'(hist_y[s2])) / 4;
        end else if (hist_fill >= 2) begin
          ox = (mx + int'(hist_x[s1])) / 2;
          oy = (my + int'(hist_y[s1])) / 2;
        end
      end
      last_x = POS_W'(ox);
      last_y = POS_W'(oy);
      res = '{last_x, last_y, 1'b1};
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] d);
    in_if.valid <= 1'b0;
    while (pos_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    apply_reg(idx, d);
  endtask

  task automatic send_sample(input logic [15:0] rx, input logic [15:0] ry, input logic sv,
                             input logic typed, input pos_t typed_pos);
    pos_t p;
    in_if.valid        <= 1'b1;
    in_if.raw_x        <= rx;
    in_if.raw_y        <= ry;
    in_if.sample_valid <= sv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    filter_sample(rx, ry, sv, p);
    pos_q.push_back(typed ? typed_pos : p);
    // random sender gap
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic stim_row_t smp(input logic [15:0] a, input logic [15:0] b, input logic v);
    return '{ROW_SAMPLE, a, b, v, 1'b0, '0, '0};
  endfunction

  function automatic stim_row_t smp_typed(input logic [15:0] a, input logic [15:0] b,
                                          input logic v, input int ex, input int ey);
    return '{ROW_SAMPLE, a, b, v, 1'b1, POS_W'(ex), POS_W'(ey)};
  endfunction

  function automatic stim_row_t reg_row(input reg_idx_e idx, input logic [15:0] d);
    return '{ROW_REG, 16'(idx), d, 1'b0, 1'b0, '0, '0};
  endfunction

  // one calibration axis: unusable, full range, random or very narrow
  task automatic pick_window(output logic [15:0] lo, output logic [15:0] hi);
    case ($urandom_range(0, 3))
      0: begin
        lo = 16'($urandom);
        hi = 16'($urandom_range(0, int'(lo)));
      end
      1: begin
        lo = 16'h0000;
        hi = 16'hffff;
      end
      2: begin
        lo = 16'($urandom_range(0, 60000));
        hi = lo + 16'($urandom_range(1, 65535 - int'(lo)));
      end
      default: begin
        lo = 16'($urandom_range(0, 65000));
        hi = lo + 16'($urandom_range(1, 8));
      end
    endcase
  endtask

  // raw value: extremes, noise, small moves, or inside the active region
  function automatic logic [15:0] pick_raw(input logic [15:0] prev, input logic [15:0] lo,
                                           input logic [15:0] hi, input logic win_ok,
                                           input logic [15:0] cen);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      1, 2:    return 16'($urandom);
      3, 4, 5: return prev + 16'($urandom_range(0, 96)) - 16'd48;
      default: begin
        if (win_ok) return 16'($urandom_range(int'(hi), int'(lo)));
        return cen + 16'($urandom_range(0, 2200)) - 16'd1100;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // reset and stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t   dir_tbl[$];
    logic [15:0] xl, xr, yt, yb, cx, cy, md, px, py, rx, ry;
    logic        win_ok;
    pos_t        typed_pos;

    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.raw_x        <= '0;
    in_if.raw_y        <= '0;
    in_if.sample_valid <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;

    pred_mode = MODE_DIRECT;
    cen_x = '0; cen_y = '0;
    win_l = '0; win_r = '0; win_t = '0; win_b = '0;
    for (int i = 0; i < 3; i++) begin
      hist_x[i] = '0;
      hist_y[i] = '0;
    end
    hist_wr = 0;
    hist_fill = 0;
    last_x = '0;
    last_y = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, short history, extremes, every mode
    dir_tbl = '{
      reg_row(REG_FILTER_MODE, 16'(MODE_WEIGHTED)),
      smp_typed(16'hffff, 16'hffff, 1'b0, 0, 0),
      smp_typed(16'h0000, 16'h0000, 1'b1, 959, 539),
      smp_typed(16'hffff, 16'hffff, 1'b1, 1007, 587),
      smp_typed(16'h0000, 16'h0000, 1'b0, 1007, 587),
      smp(16'hffff, 16'h0000, 1'b1),
      reg_row(REG_CENTER_X, 16'hffff),
      reg_row(REG_CENTER_Y, 16'hffff),
      reg_row(REG_FILTER_MODE, 16'(MODE_MEAN2)),
      smp(16'h1234, 16'habcd, 1'b1),
      smp(16'hffff, 16'hffff, 1'b1),
      reg_row(REG_WINDOW_LEFT, 16'h1000),
      reg_row(REG_WINDOW_RIGHT, 16'hf000),
      reg_row(REG_WINDOW_TOP, 16'h2000),
      reg_row(REG_WINDOW_BOTTOM, 16'he000),
      smp(16'h0000, 16'h0000, 1'b1),
      smp(16'hffff, 16'hffff, 1'b1),
      smp(16'h1000, 16'h2000, 1'b1),
      smp(16'hf000, 16'he000, 1'b1),
      smp(16'h8000, 16'h8000, 1'b1),
      smp(16'h8010, 16'h7ff0, 1'b0),
      smp(16'h8010, 16'h7ff0, 1'b1),
      reg_row(REG_FILTER_MODE, 16'(MODE_DIRECT_B)),
      reg_row(REG_WINDOW_LEFT, 16'h0000),
      reg_row(REG_WINDOW_RIGHT, 16'hffff),
      reg_row(REG_WINDOW_TOP, 16'h0000),
      reg_row(REG_WINDOW_BOTTOM, 16'hffff),
      smp(16'hffff, 16'h0000, 1'b1),
      smp(16'h0001, 16'hfffe, 1'b1),
      smp(16'h5555, 16'haaaa, 1'b1),
      reg_row(REG_FILTER_MODE, 16'(MODE_DIRECT)),
      reg_row(REG_WINDOW_RIGHT, 16'h0000),
      reg_row(REG_CENTER_X, 16'h0000),
      reg_row(REG_CENTER_Y, 16'h8000),
      smp(16'h0000, 16'h8000, 1'b1),
      smp(16'h7fff, 16'h8400, 1'b1)
    };

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_REG) begin
        write_reg(reg_idx_e'(dir_tbl[i].a[CFG_IDX_W-1:0]), dir_tbl[i].b);
      end else begin
        typed_pos = '{dir_tbl[i].ex, dir_tbl[i].ey, dir_tbl[i].v};
        send_sample(dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].v, dir_tbl[i].typed, typed_pos);
      end
    end

    // random phases, each under a fresh calibration
    px = 16'h8000;
    py = 16'h8000;
    for (int ph = 0; ph < PHASES; ph++) begin
      pick_window(xl, xr);
      pick_window(yt, yb);
      cx = 16'($urandom);
      cy = 16'($urandom);
      if (ph == 0) begin
        xl = '0; xr = '1; yt = '0; yb = '1;
        cx = '1; cy = '1;
      end else if (ph == 1) begin
        xl = '0; xr = '0; yt = '0; yb = '0;
        cx = '0; cy = '0;
      end
      md = 16'($urandom);
      md[1:0] = 2'(ph % 4);
      if (ph == PHASES - 1) no_idle = 1'b1;
      write_reg(REG_FILTER_MODE, md);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_WINDOW_LEFT, xl);
      write_reg(REG_WINDOW_RIGHT, xr);
      write_reg(REG_WINDOW_TOP, yt);
      write_reg(REG_WINDOW_BOTTOM, yb);
      win_ok = (xr > xl) && (yb > yt);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long output stall while samples keep coming
        if (ph == 2 && n == 10) hold_req = 1'b1;
        // sender waits for the filter to drain
        if (ph == 4 && n == 30) begin
          in_if.valid <= 1'b0;
          while (pos_q.size() != 0) @(posedge clk);
        end
        rx = pick_raw(px, xl, xr, win_ok, cx);
        ry = pick_raw(py, yt, yb, win_ok, cy);
        px = rx;
        py = ry;
        send_sample(rx, ry, $urandom_range(0, 6) != 0, 1'b0, '0);
      end
    end

    // drain and finish
    in_if.valid <= 1'b0;
    while (pos_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (err_cnt == 0 && pos_q.size() == 0) begin
      $display("pointer_position_filter: match");
    end else begin
      $display("pointer_position_filter: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: ready bursts and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // compare each result beat with the oldest expected position
  always @(posedge clk) begin
    pos_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pos_q.size() == 0) begin
        $error("unexpected result beat: pos_x %0d pos_y %0d pos_valid %0b",
               out_if.pos_x, out_if.pos_y, out_if.pos_valid);
        err_cnt++;
      end else begin
        e = pos_q.pop_front();
        if (out_if.pos_x !== e.x) begin
          $error("pos_x: expected %0d, got %0d", e.x, out_if.pos_x);
          err_cnt++;
        end
        if (out_if.pos_y !== e.y) begin
          $error("pos_y: expected %0d, got %0d", e.y, out_if.pos_y);
          err_cnt++;
        end
        if (out_if.pos_valid !== e.v) begin
          $error("pos_valid: expected %0b, got %0b", e.v, out_if.pos_valid);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("pointer_position_filter: mismatch");
    $finish;
  end

endmodule
